### hdl/mxfp4_pkg.sv
// mxfp4_pkg: shared constants and the fp4 e2m1 to bf16 conversion function
// used by the tile dequantizer core and its converter
// no dependencies
package mxfp4_pkg;

	localparam int unsigned SCALE_BYTES = 128;
	localparam logic [11:0] POS_MAX     = 12'hFFF;

	// fp4 code (4 bits) with e8m0 scale to bf16 bit pattern
	function automatic logic [15:0] fp4_to_bf16(input logic [3:0] code, input logic [7:0] e);
		logic        sgn;
		logic [2:0]  mag;
		logic [1:0]  off;
		logic        m;
		logic [9:0]  be;
		logic [15:0] r;
		sgn = code[3];
		mag = code[2:0];
		off = mag[2:1];
		m   = mag[0] & (mag != 3'd1);
		be  = {2'b00, e} + {8'd0, off};
		if (e == 8'd0 || e == 8'hFF) begin
			r = (code >= 4'd9) ? 16'h8000 : 16'h0000;
		end else if (mag == 3'd0) begin
			r = 16'h0000;
		end else if (be >= 10'd256) begin
			r = {sgn, 15'h7F80};
		end else if (be == 10'd1) begin
			r = {sgn, 8'h00, 1'b1, m, 5'd0};
		end else begin
			r = {sgn, be[7:0] - 8'd1, m, 6'd0};
		end
		return r;
	endfunction

endpackage

### hdl/mxfp4_tile_dequantizer_core.sv
// mxfp4_tile_dequantizer_core: mxfp4 tile to bf16 stream dequantizer, top level
// depends on mxfp4_pkg and mxfp4_conv
//
// channel | dir | tdata                      | tuser          | tlast
// s_axis  | in  | [7:0] tile_byte            | first_of_tile  | -
// m_axis  | out | [15:0] value_bits          | last_of_pair   | last_of_tile
//
// a data byte is accepted into the s1 stage, its two scales are read into s1
// at that edge, and its two results then leave through the output register,
// low first and high from the hold slot; s1 can take the next data byte while
// those results still wait; scale and gap bytes are taken one per cycle while
// s_axis_tready is high; the output holds while m_axis_tready is low and
// s_axis_tready waits for the s1 stage to be free or to move on this cycle
// reset clears the position counter and all valid flags; scales need writing
module mxfp4_tile_dequantizer_core import mxfp4_pkg::*; #(
	parameter int unsigned COLUMNS     = 128,
	parameter int unsigned ROWS        = 32,
	parameter int unsigned DATA_OFFSET = 512
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] tile_byte
	input  logic        s_axis_tuser,   // first_of_tile
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [15:0] m_axis_tdata,   // [15:0] value_bits
	output logic        m_axis_tuser,   // last_of_pair
	output logic        m_axis_tlast    // last_of_tile
);
	localparam int unsigned PAIRS = COLUMNS / 2;
	localparam int unsigned TOTAL = ROWS * PAIRS;

	// position and column counter
	logic [11:0] pos_q;
	logic [9:0]  pair_q;   // pair index within row, only tracked in data area
	logic [11:0] pos;
	logic        in_fire;
	logic        is_scale, is_data;
	logic [23:0] k;

	// scale store: even and odd columns in two banks of 64, registered read
	logic [7:0] scale_even_q [SCALE_BYTES / 2];
	logic [7:0] scale_odd_q  [SCALE_BYTES / 2];

	// s1 stage: data byte with its two scales
	logic        dv_s1;
	logic [7:0]  byte_s1;
	logic        last_s1;
	logic [7:0]  scale_lo_s1;
	logic [7:0]  scale_hi_s1;
	logic        s1_move;

	// output: hold slot for the high result
	logic        out_v_q;
	logic [15:0] out_d_q;
	logic        out_u_q, out_l_q;
	logic        hi_v_q;
	logic [15:0] hi_d_q;
	logic        hi_l_q;

	logic [9:0]  pair_cur;
	logic [15:0] bf_lo, bf_hi;
	logic        out_free;

	assign pos      = s_axis_tuser ? 12'd0 : pos_q;
	assign is_scale = (32'(pos) < SCALE_BYTES);
	assign k        = 24'(pos) - 24'(DATA_OFFSET);
	assign is_data  = (32'(pos) >= DATA_OFFSET) && (32'(k) < TOTAL);
	// pair index resets on entering the data area
	assign pair_cur = (32'(pos) == DATA_OFFSET) ? 10'd0 : pair_q;

	// s1 moves on only when no high result waits and the output is empty or drains
	assign out_free      = !hi_v_q && (!out_v_q || m_axis_tready);
	assign s1_move       = dv_s1 && out_free;
	assign s_axis_tready = !dv_s1 || s1_move;
	assign in_fire       = s_axis_tvalid && s_axis_tready;

	mxfp4_conv u_conv (
		.data_byte (byte_s1),
		.scale_lo  (scale_lo_s1),
		.scale_hi  (scale_hi_s1),
		.bf_lo     (bf_lo),
		.bf_hi     (bf_hi)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= 12'd0;
			pair_q <= 10'd0;
		end else if (in_fire) begin
			pos_q <= (pos < POS_MAX) ? pos + 12'd1 : POS_MAX;
			// a saturated counter repeats the same byte position
			if (is_data && pos != POS_MAX) begin
				pair_q <= (32'(pair_cur) == PAIRS - 1) ? 10'd0 : pair_cur + 10'd1;
			end
		end
	end

	// even column bank
	always_ff @(posedge clk) begin
		if (in_fire && is_scale && !pos[0]) begin
			scale_even_q[pos[6:1]] <= s_axis_tdata;
		end
		if (in_fire && is_data) begin
			scale_lo_s1 <= scale_even_q[pair_cur[5:0]];
		end
	end

	// odd column bank
	always_ff @(posedge clk) begin
		if (in_fire && is_scale && pos[0]) begin
			scale_odd_q[pos[6:1]] <= s_axis_tdata;
		end
		if (in_fire && is_data) begin
			scale_hi_s1 <= scale_odd_q[pair_cur[5:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_s1 <= 1'b0;
		end else if (in_fire && is_data) begin
			dv_s1 <= 1'b1;
		end else if (s1_move) begin
			dv_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire && is_data) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= (32'(k) == TOTAL - 1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
			hi_v_q  <= 1'b0;
		end else begin
			if (s1_move) begin
				out_v_q <= 1'b1;
				hi_v_q  <= 1'b1;
			end else if (hi_v_q && (!out_v_q || m_axis_tready)) begin
				out_v_q <= 1'b1;
				hi_v_q  <= 1'b0;
			end else if (m_axis_tready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_move) begin
			out_d_q <= bf_lo;
			out_u_q <= 1'b0;
			out_l_q <= 1'b0;
			hi_d_q  <= bf_hi;
			hi_l_q  <= last_s1;
		end else if (hi_v_q && (!out_v_q || m_axis_tready)) begin
			out_d_q <= hi_d_q;
			out_u_q <= 1'b1;
			out_l_q <= hi_l_q;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_d_q;
	assign m_axis_tuser  = out_u_q;
	assign m_axis_tlast  = out_l_q;
endmodule

### hdl/mxfp4_conv.sv
// mxfp4_conv: converts the two nibbles of one data byte to bf16
// depends on mxfp4_pkg
module mxfp4_conv import mxfp4_pkg::*; (
	input  logic [7:0]  data_byte,
	input  logic [7:0]  scale_lo,
	input  logic [7:0]  scale_hi,
	output logic [15:0] bf_lo,
	output logic [15:0] bf_hi
);
	assign bf_lo = fp4_to_bf16(data_byte[3:0], scale_lo);
	assign bf_hi = fp4_to_bf16(data_byte[7:4], scale_hi);
endmodule

### verif/mxfp4_tile_dequantizer_core_tb.sv
// mxfp4_tile_dequantizer_core_tb: self-checking testbench for the tile dequantizer
// drives tile bytes on s_axis and checks every bf16 result on m_axis
// depends on mxfp4_pkg and mxfp4_tile_dequantizer_core
module mxfp4_tile_dequantizer_core_tb;
	import mxfp4_pkg::*;

	localparam int unsigned COLUMNS     = 128;
	localparam int unsigned ROWS        = 32;
	localparam int unsigned DATA_OFFSET = 512;
	localparam int unsigned PAIRS       = COLUMNS / 2;
	localparam int unsigned TOTAL       = ROWS * PAIRS;

	typedef struct packed {
		logic [7:0] tile_byte;
		logic       first_of_tile;
	} byte_req_t;

	typedef struct packed {
		logic [15:0] value_bits;
		logic        last_of_pair;
		logic        last_of_tile;
	} elem_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [7:0]  s_axis_tdata;   // [7:0] tile_byte
	logic        s_axis_tuser;   // first_of_tile
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [15:0] m_axis_tdata;   // [15:0] value_bits
	logic        m_axis_tuser;   // last_of_pair
	logic        m_axis_tlast;   // last_of_tile

	mxfp4_tile_dequantizer_core #(
		.COLUMNS(COLUMNS), .ROWS(ROWS), .DATA_OFFSET(DATA_OFFSET)
	) dut (.*);

	byte_req_t   pending_bytes[$];
	elem_t       expected_elems[$];
	logic [11:0] pos_model;
	logic [7:0]  scale_model[128];
	int          mismatches;
	int          send_idle_pct;
	int          recv_idle_pct;
	bit          hold_off;
	bit          in_taken;

	// independent e2m1 times 2^(e-127) to bf16
	function automatic logic [15:0] bf16_of_code(input logic [3:0] code, input logic [7:0] e);
		logic [8:0] biased;
		logic       mant;
		logic [1:0] extra;
		if (e == 8'd0 || e == 8'd255)
			return (code >= 4'd9) ? 16'h8000 : 16'h0000;
		if (code[2:0] == 3'd0)
			return 16'h0000;
		case (code[2:0])
			3'd1: begin extra = 2'd0; mant = 1'b0; end
			3'd2: begin extra = 2'd1; mant = 1'b0; end
			3'd3: begin extra = 2'd1; mant = 1'b1; end
			3'd4: begin extra = 2'd2; mant = 1'b0; end
			3'd5: begin extra = 2'd2; mant = 1'b1; end
			3'd6: begin extra = 2'd3; mant = 1'b0; end
			default: begin extra = 2'd3; mant = 1'b1; end
		endcase
		// level 0.5 sits one below the e2m1 bias, hence the minus one
		biased = {1'b0, e} + extra - 9'd1;
		if (biased >= 9'd255)
			return {code[3], 15'h7F80};
		if (biased == 9'd0)
			return {code[3], 8'h00, 1'b1, mant, 5'd0};
		return {code[3], biased[7:0], mant, 6'd0};
	endfunction

	// advance the position model and queue what this byte produces
	task automatic predict_byte(input byte_req_t r);
		logic [11:0] p;
		int unsigned k, col;
		elem_t lo, hi;
		p = r.first_of_tile ? 12'd0 : pos_model;
		if (p < SCALE_BYTES) begin
			scale_model[p[6:0]] = r.tile_byte;
		end else if (p >= DATA_OFFSET && (p - DATA_OFFSET) < TOTAL) begin
			k   = p - DATA_OFFSET;
			col = (k % PAIRS) * 2;
			lo.value_bits   = bf16_of_code(r.tile_byte[3:0], scale_model[col % 128]);
			lo.last_of_pair = 1'b0;
			lo.last_of_tile = 1'b0;
			hi.value_bits   = bf16_of_code(r.tile_byte[7:4], scale_model[(col + 1) % 128]);
			hi.last_of_pair = 1'b1;
			hi.last_of_tile = (k == TOTAL - 1);
			expected_elems.push_back(lo);
			expected_elems.push_back(hi);
		end
		pos_model = (p < POS_MAX) ? p + 12'd1 : POS_MAX;
	endtask

	task automatic report_mismatch(input string what, input int got, input int want);
		$display("mismatch %s: got %0h expected %0h", what, got, want);
		mismatches++;
	endtask

	task automatic push_byte(input logic [7:0] b, input logic f);
		byte_req_t r;
		r.tile_byte = b;
		r.first_of_tile = f;
		pending_bytes.push_back(r);
	endtask

	// one tile: scales, gap, then n data bytes (n may exceed the tile)
	task automatic push_tile(input int n_data, input int scale_mode);
		logic [7:0] s;
		for (int i = 0; i < DATA_OFFSET; i++) begin
			if (i < SCALE_BYTES) begin
				case (scale_mode)
					0: s = 8'($urandom_range(0, 255));
					1: s = 8'($urandom_range(110, 140));
					2: s = (i % 4 == 0) ? 8'd0 : (i % 4 == 1) ? 8'd255 :
						(i % 4 == 2) ? 8'd1 : 8'd254;
					default: s = ($urandom_range(0, 3) == 0) ? 8'd0 :
						8'($urandom_range(1, 254));
				endcase
			end else begin
				s = 8'($urandom_range(0, 255));
			end
			push_byte(s, i == 0);
		end
		for (int i = 0; i < n_data; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
	endtask

	always #6 clk = ~clk;

	// remembers whether the request on the bus was taken at the last rising edge
	always @(posedge clk) begin
		in_taken <= s_axis_tvalid && s_axis_tready;
	end

	// driver: changes on the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
			s_axis_tuser  <= 1'b0;
		end else begin
			// a held request stays until accepted
			if (s_axis_tvalid && !in_taken) begin
			end else if (pending_bytes.size() != 0 && !hold_off &&
					$urandom_range(0, 99) >= send_idle_pct) begin
				byte_req_t r;
				r = pending_bytes.pop_front();
				predict_byte(r);
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= r.tile_byte;
				s_axis_tuser  <= r.first_of_tile;
			end else begin
				s_axis_tvalid <= 1'b0;
			end
		end
	end

	// receiver stalls also change on the falling edge
	always @(negedge clk or negedge arst_n) begin
		if (!arst_n)
			m_axis_tready <= 1'b0;
		else
			m_axis_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
	end

	// monitor: results are sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_elems.size() == 0) begin
				report_mismatch("unexpected result", m_axis_tdata, 0);
			end else begin
				elem_t e;
				e = expected_elems.pop_front();
				if (m_axis_tdata !== e.value_bits)
					report_mismatch("value_bits", m_axis_tdata, e.value_bits);
				if (m_axis_tuser !== e.last_of_pair)
					report_mismatch("last_of_pair", m_axis_tuser, e.last_of_pair);
				if (m_axis_tlast !== e.last_of_tile)
					report_mismatch("last_of_tile", m_axis_tlast, e.last_of_tile);
			end
		end
	end

	task automatic wait_drained();
		while (pending_bytes.size() != 0 || s_axis_tvalid) @(posedge clk);
		while (expected_elems.size() != 0) @(posedge clk);
	endtask

	initial begin
		clk = 1'b0;
		mismatches = 0;
		send_idle_pct = 21;
		recv_idle_pct = 78;
		hold_off = 1'b0;
		pos_model = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: extreme scales against every code
		for (int i = 0; i < DATA_OFFSET; i++)
			push_byte(i < SCALE_BYTES ? ((i % 4 == 0) ? 8'd0 : (i % 4 == 1) ? 8'd255 :
				(i % 4 == 2) ? 8'd1 : 8'd254) : 8'd0, i == 0);
		for (int i = 0; i < 16; i++)
			push_byte({i[3:0], i[3:0]}, 1'b0);
		push_byte(8'hF0, 1'b0);
		push_byte(8'h0F, 1'b0);
		push_byte(8'h98, 1'b0);
		push_byte(8'h89, 1'b0);

		// pause the sender in the data bytes until every result has come
		while (pending_bytes.size() > 10) @(posedge clk);
		hold_off = 1'b1;
		while (s_axis_tvalid || expected_elems.size() != 0) @(posedge clk);
		hold_off = 1'b0;
		wait_drained();

		send_idle_pct = 78;
		recv_idle_pct = 21;
		push_byte(8'h5A, 1'b1);  // broken tile: realign in the scale region
		push_tile(120, 3);
		wait_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		// more data bytes of the same tile, back to back
		for (int i = 0; i < 180; i++)
			push_byte(8'($urandom_range(0, 255)), 1'b0);
		wait_drained();

		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#12000000;
		$display("FAILED: results differ");
		$finish;
	end

endmodule

### files.f
hdl/mxfp4_pkg.sv
hdl/mxfp4_conv.sv
hdl/mxfp4_tile_dequantizer_core.sv
verif/mxfp4_tile_dequantizer_core_tb.sv
